@@ design/pcc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pcc_pkg;

   localparam int N_W       = 4;
   localparam int COUNT_W   = 29;
   localparam int MAX_N     = 12;
   // wide enough for 15!, the largest product a 4-bit n can build
   localparam int ACC_W     = 48;
   localparam int DIV_CHUNK = 8;
   localparam int DIV_STEPS = ACC_W / DIV_CHUNK;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic OP_PERM = 1'b0;
   localparam logic OP_COMB = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef struct packed {
      logic           div_sel;  // 0: multiply by operand, 1: one chunk of divide by operand
      logic [N_W-1:0] operand;
   } arith_cmd_type;

endpackage

`default_nettype wire

@@ design/pcc_arith.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pcc_arith (
   input  wire  pcc_pkg::arith_cmd_type     cmd,
   input  wire  logic [pcc_pkg::ACC_W-1:0]  acc_in,
   input  wire  logic [pcc_pkg::N_W-1:0]    rem_in,
   output logic [pcc_pkg::ACC_W-1:0]        acc_out,
   output logic [pcc_pkg::N_W-1:0]          rem_out
);
   import pcc_pkg::*;

   logic [ACC_W+N_W-1:0] product;
   logic [ACC_W-1:0]     div_d;
   logic [N_W-1:0]       div_r;
   logic [N_W:0]         trial;

   assign product = acc_in * cmd.operand;

   // restoring division, DIV_CHUNK quotient bits per pass
   always_comb begin
      div_d = acc_in;
      div_r = rem_in;
      trial = '0;
      for (int j = 0; j < DIV_CHUNK; j++) begin
         trial = {div_r, div_d[ACC_W-1]};
         div_d = {div_d[ACC_W-2:0], 1'b0};
         if (trial >= {1'b0, cmd.operand}) begin
            div_r    = N_W'(trial - {1'b0, cmd.operand});
            div_d[0] = 1'b1;
         end else begin
            div_r = trial[N_W-1:0];
         end
      end
   end

   always_comb begin
      if (cmd.div_sel) begin
         acc_out = div_d;
         rem_out = div_r;
      end else begin
         acc_out = product[ACC_W-1:0];
         rem_out = '0;
      end
   end

endmodule

`default_nettype wire

@@ design/permutation_combination_count.sv @@
// Permutation / combination counter.
// Input channel req_*: n, k and opcode (0 = nPk, 1 = nCk). req_stall is high
// while an item is in work; one item is taken at a time.
// Result channel rsp_*: the count and a status bit (1 when k > n or n > 12,
// count then 0). A count that does not fit 29 bits saturates.
// The transfer is taken in the idle state, then one multiply pass per factor
// through the shared arithmetic unit; nCk adds six divide passes (8 quotient
// bits each) per factor; the finish state then loads the output register
// once that register is free.
// The result sits in an output register, so a new item is taken while a
// result still waits; if the receiver stalls, the next result waits in the
// sequencer until the register frees up.
// Reset (synchronous, active high) returns the sequencer to idle and drops
// rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module permutation_combination_count #(
   parameter int MAX_N = pcc_pkg::MAX_N
) (
   input  wire  logic                          clock,
   input  wire  logic                          reset,
   input  wire  logic                          req_valid,
   output logic                                req_stall,
   input  wire  logic [pcc_pkg::N_W-1:0]       req_n_count,
   input  wire  logic [pcc_pkg::N_W-1:0]       req_k_count,
   input  wire  logic                          req_opcode,
   output logic                                rsp_valid,
   input  wire  logic                          rsp_stall,
   output logic [pcc_pkg::COUNT_W-1:0]         rsp_count_value,
   output logic                                rsp_status
);
   import pcc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   logic [1:0]           state_ff, state_in;
   logic [N_W-1:0]       n_ff, n_in;
   logic [N_W-1:0]       k_ff, k_in;
   logic                 op_ff, op_in;
   logic                 err_ff, err_in;
   logic [N_W-1:0]       step_ff, step_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [N_W-1:0]       rem_ff, rem_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_status_ff, rsp_status_in;

   arith_cmd_type        cmd;
   logic [ACC_W-1:0]     unit_acc;
   logic [N_W-1:0]       unit_rem;
   logic [N_W-1:0]       factor;
   logic                 req_xfer;
   logic                 rsp_free;
   logic                 bad_item;
   logic                 last_step;

   pcc_arith u_arith (
      .cmd     (cmd),
      .acc_in  (acc_ff),
      .rem_in  (rem_ff),
      .acc_out (unit_acc),
      .rem_out (unit_rem)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign bad_item  = (req_k_count > req_n_count) || (int'(req_n_count) > MAX_N);
   assign last_step = (step_ff == k_ff);

   // nPk factors run n down to n-k+1, nCk factors run n-k+1 up to n
   assign factor = (op_ff == OP_PERM) ? N_W'(n_ff - step_ff + 1'b1)
                                      : N_W'(n_ff - k_ff + step_ff);

   always_comb begin
      cmd.div_sel = (state_ff == ST_DIV);
      cmd.operand = (state_ff == ST_DIV) ? step_ff : factor;
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      op_in         = op_ff;
      err_in        = err_ff;
      step_in       = step_ff;
      div_cnt_in    = div_cnt_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               n_in    = req_n_count;
               k_in    = req_k_count;
               op_in   = req_opcode;
               err_in  = bad_item;
               step_in = N_W'(1);
               acc_in  = ACC_W'(1);
               if (bad_item || (req_k_count == '0)) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            acc_in = unit_acc;
            if (op_ff == OP_COMB) begin
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end else if (last_step) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DIV: begin
            acc_in     = unit_acc;
            rem_in     = unit_rem;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               if (last_step) begin
                  state_in = ST_FINISH;
               end else begin
                  step_in  = step_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = err_ff ? STATUS_ERR : STATUS_OK;
               if (err_ff) begin
                  rsp_value_in = '0;
               end else if (acc_ff > ACC_W'(COUNT_MAX)) begin
                  rsp_value_in = COUNT_MAX;
               end else begin
                  rsp_value_in = acc_ff[COUNT_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      k_ff          <= k_in;
      op_ff         <= op_in;
      err_ff        <= err_in;
      step_ff       <= step_in;
      div_cnt_ff    <= div_cnt_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_count_value = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> req_stall)
      else $error("input taken but block still ready");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_ERR) |-> (rsp_count_value == '0))
      else $error("error result with nonzero count");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish state");

   a_exact_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_cnt_ff == DIV_LAST) |=> (rem_ff == '0))
      else $error("combination step left a remainder");

endmodule

`default_nettype wire

@@ dv/permutation_combination_count_tb.sv @@
`timescale 1ns / 1ps

module permutation_combination_count_tb;
   import pcc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 600_000;
   localparam int unsigned DRAIN_CYCLES = 100;
   localparam int unsigned HOLD_CYCLES  = 400;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN} stall_mode_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_value;
      logic               status;
   } count_result_type;

   typedef struct packed {
      logic [N_W-1:0] n_count;
      logic [N_W-1:0] k_count;
      logic           opcode;
   } selection_type;

   class count_scoreboard;
      count_result_type expected_counts[$];
      int unsigned      mismatches = 0;

      function count_result_type predict_count(int unsigned n, int unsigned k, logic op);
         count_result_type res;
         longint unsigned  acc;
         int unsigned      i;
         acc = 1;
         if (k > n || n > MAX_N) begin
            res.count_value = '0;
            res.status      = STATUS_ERR;
            return res;
         end
         for (i = 1; i <= k; i++) begin
            if (op == OP_PERM)
               acc = acc * (n - i + 1);
            else
               acc = (acc * (n - k + i)) / i;  // exact at every step
         end
         if (acc > COUNT_MAX)
            acc = COUNT_MAX;
         res.count_value = acc[COUNT_W-1:0];
         res.status      = STATUS_OK;
         return res;
      endfunction

      function void note_request(logic [N_W-1:0] n, logic [N_W-1:0] k, logic op);
         expected_counts.push_back(predict_count(32'(n), 32'(k), op));
      endfunction

      function void check_response(logic [COUNT_W-1:0] value, logic status);
         count_result_type want;
         if (expected_counts.size() == 0) begin
            $error("unexpected result: count_value %0d status %0d", value, status);
            mismatches++;
            return;
         end
         want = expected_counts.pop_front();
         if (value !== want.count_value) begin
            $error("count_value mismatch: expected %0d, actual %0d", want.count_value, value);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_counts.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [N_W-1:0]       req_n_count = '0;
   logic [N_W-1:0]       req_k_count = '0;
   logic                 req_opcode = OP_PERM;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COUNT_W-1:0]   rsp_count_value;
   logic                 rsp_status;

   stall_mode_type       stall_mode = STALL_NONE;
   logic                 hold_toggle = 1'b0;
   logic                 hold_seen = 1'b0;
   int unsigned          hold_left = 0;
   int unsigned          rx_tick = 0;
   int unsigned          cycle_count = 0;

   count_scoreboard      counts_sb = new();

   selection_type directed_items [18] = '{
      '{4'd0,  4'd0,  OP_PERM},
      '{4'd0,  4'd0,  OP_COMB},
      '{4'd12, 4'd12, OP_PERM},
      '{4'd12, 4'd12, OP_COMB},
      '{4'd12, 4'd6,  OP_COMB},
      '{4'd12, 4'd0,  OP_PERM},
      '{4'd12, 4'd0,  OP_COMB},
      '{4'd12, 4'd11, OP_PERM},
      '{4'd12, 4'd1,  OP_PERM},
      '{4'd1,  4'd1,  OP_COMB},
      '{4'd10, 4'd3,  OP_PERM},
      '{4'd10, 4'd3,  OP_COMB},
      '{4'd5,  4'd6,  OP_PERM},
      '{4'd7,  4'd8,  OP_COMB},
      '{4'd0,  4'd15, OP_PERM},
      '{4'd13, 4'd0,  OP_COMB},
      '{4'd15, 4'd3,  OP_COMB},
      '{4'd15, 4'd15, OP_PERM}
   };

   permutation_combination_count DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_n_count     (req_n_count),
      .req_k_count     (req_k_count),
      .req_opcode      (req_opcode),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_count_value (rsp_count_value),
      .rsp_status      (rsp_status)
   );

   always #5 clock = ~clock;

   // transfer monitors
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         counts_sb.note_request(req_n_count, req_k_count, req_opcode);
      if (!reset && rsp_valid && !rsp_stall)
         counts_sb.check_response(rsp_count_value, rsp_status);
   end

   // receiver: long hold-off on request, otherwise the selected stall pattern
   always @(posedge clock) begin
      rx_tick <= rx_tick + 1;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:    rsp_stall <= 1'b0;
            STALL_LIGHT:   rsp_stall <= ($urandom_range(3) == 0);
            STALL_HEAVY:   rsp_stall <= ($urandom_range(9) < 7);
            STALL_PATTERN: rsp_stall <= ((rx_tick % 11) < 4);
            default:       rsp_stall <= 1'b0;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("permutation_combination_count regression: fail");
         $finish;
      end
   end

   // leaves valid high; the caller lowers it when a gap follows
   task automatic offer_item(input selection_type item);
      req_valid   <= 1'b1;
      req_n_count <= item.n_count;
      req_k_count <= item.k_count;
      req_opcode  <= item.opcode;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles)
         @(posedge clock);
   endtask

   task automatic wait_for_counts();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (counts_sb.pending() != 0);
   endtask

   function automatic selection_type random_selection();
      selection_type item;
      int unsigned   pick;
      int unsigned   n;
      pick = $urandom_range(99);
      item.opcode = 1'($urandom_range(1));
      if (pick < 70) begin
         n = $urandom_range(MAX_N);
         item.n_count = N_W'(n);
         item.k_count = N_W'($urandom_range(n));
      end else if (pick < 85) begin
         // k above n
         n = $urandom_range(14);
         item.n_count = N_W'(n);
         item.k_count = N_W'($urandom_range(15, n + 1));
      end else begin
         item.n_count = N_W'($urandom_range(15));
         item.k_count = N_W'($urandom_range(15));
      end
      return item;
   endfunction

   task automatic run_random(input int unsigned count, input bit bursty);
      int unsigned burst_left;
      burst_left = $urandom_range(12, 1);
      repeat (count) begin
         offer_item(random_selection());
         if (bursty) begin
            burst_left--;
            if (burst_left == 0) begin
               pause_sender($urandom_range(30, 1));
               burst_left = $urandom_range(12, 1);
            end
         end
      end
   endtask

   initial begin
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_items[i])
         offer_item(directed_items[i]);
      wait_for_counts();

      run_random(150, 1'b0);
      wait_for_counts();

      stall_mode <= STALL_LIGHT;
      run_random(150, 1'b1);

      // receiver holds off while the sender keeps offering, so the block backs up
      hold_toggle <= ~hold_toggle;
      run_random(20, 1'b0);
      wait_for_counts();

      stall_mode <= STALL_HEAVY;
      run_random(150, 1'b1);

      stall_mode <= STALL_PATTERN;
      run_random(150, 1'b1);

      wait_for_counts();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (counts_sb.mismatches == 0 && counts_sb.pending() == 0)
         $display("permutation_combination_count regression: pass");
      else
         $display("permutation_combination_count regression: fail");
      $finish;
   end

endmodule
